### rtl/pscalloc_pkg.sv
// Package for the page and chunk allocator: sizes, opcodes, status codes,
// sequencer states. No dependencies.
package pscalloc_pkg;
  localparam int PAGES = 1024;
  localparam int CPP = 4;
  localparam int PW = $clog2(PAGES);
  localparam int SW = $clog2(CPP);
  localparam int CW = PW + SW;
  localparam int TOTAL = PAGES * CPP;
  localparam int NW = $clog2(CPP + 1);
  localparam logic [CPP-1:0] FULL_MASK = {CPP{1'b1}};
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef enum logic [1:0] {
    FN_PALLOC = 2'd0,
    FN_PFREE  = 2'd1,
    FN_CALLOC = 2'd2,
    FN_CFREE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_DUP  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_EXEC, S_SPLIT, S_CPOP, S_WALK, S_WALK2, S_PUSHPG, S_OUT
  } state_t;
endpackage

### rtl/pscalloc_ram.sv
// Generic single-port-write, single-read synchronous RAM with a registered read.
// No dependencies.
module pscalloc_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/page_and_subpage_chunk_allocator.sv
// Top level of the page and chunk allocator: sequencer, list heads, counters.
// Depends on pscalloc_pkg and pscalloc_ram (page links, chunk links, split table).
//
// Use: present one operation on in_valid/in_ready with func, page_number and
// chunk_number; one result comes back on out_valid/out_ready with status,
// granted_page, granted_chunk and free_pages.
// Page allocate, page free and chunk free of a page not made whole go through
// read, execute and output states; chunk allocate adds a pop state, and first
// splits a page and reads again when the chunk list is empty but a page is free.
// A chunk free that makes a page whole walks the chunk list, each step waiting
// on a chunk link read, and then pushes the page back onto the page list.
// The block holds one operation at a time; in_ready is high again in the same
// cycle as the result lands in the output register, and the next beat is taken
// while that result waits.
// A stalled receiver holds the result and, after one more operation finishes,
// blocks input.
// Reset empties both lists and zeroes the page count, then a clearing pass marks
// every split table entry unused; in_ready stays low meanwhile.
module page_and_subpage_chunk_allocator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [9:0]              page_number,
  input  logic [11:0]             chunk_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [9:0]              granted_page,
  output logic [11:0]             granted_chunk,
  output logic [10:0]             free_pages
);
  import pscalloc_pkg::*;

  state_t state, state_next;
  func_t  op;
  logic [PW-1:0] op_page;
  logic [SW-1:0] op_sub;
  logic [PW:0]   page_head;
  logic [CW:0]   chunk_head;
  logic [10:0]   page_total;
  logic [PW-1:0] clr_addr;
  logic [SW-1:0] split_i;
  logic [CW:0]   cur, prev;
  logic [CW:0]   walk_cnt;
  logic          walk_over;
  logic [1:0]    r_status;
  logic [PW-1:0] r_gpage;
  logic [CW-1:0] r_gchunk;
  logic          res_valid;

  // page links
  logic          pl_we;
  logic [PW-1:0] pl_wa, pl_ra;
  logic [PW:0]   pl_wd, pl_rd;
  // chunk links
  logic          cl_we;
  logic [CW-1:0] cl_wa, cl_ra;
  logic [CW:0]   cl_wd, cl_rd;
  // split table {valid, mask, count}
  logic          st_we;
  logic [PW-1:0] st_wa, st_ra;
  logic [CPP+NW:0] st_wd, st_rd;

  pscalloc_ram #(.DW(PW+1), .DEPTH(PAGES)) u_plink (
    .clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
  pscalloc_ram #(.DW(CW+1), .DEPTH(TOTAL)) u_clink (
    .clk, .we(cl_we), .waddr(cl_wa), .wdata(cl_wd), .raddr(cl_ra), .rdata(cl_rd));
  pscalloc_ram #(.DW(CPP+NW+1), .DEPTH(PAGES)) u_split (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

  logic          in_acc, out_acc;
  logic          ph_empty, ch_empty;
  logic          st_valid;
  logic [CPP-1:0] st_mask, bit_sel;
  logic [NW-1:0]  st_cnt;
  logic [PW-1:0]  hc_page;
  logic [SW-1:0]  hc_sub;
  logic [CW-1:0]  split_chunk;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign in_ready = (state == S_IDLE);
  assign ph_empty = page_head[PW];
  assign ch_empty = chunk_head[CW];
  assign st_valid = st_rd[CPP+NW];
  assign st_mask  = st_rd[CPP+NW-1:NW];
  assign st_cnt   = st_rd[NW-1:0];
  assign hc_page  = chunk_head[CW-1:SW];
  assign hc_sub   = chunk_head[SW-1:0];
  assign split_chunk = {page_head[PW-1:0], split_i};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == PW'(PAGES - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_acc) state_next = S_RD;
      S_RD:     state_next = S_EXEC;
      S_EXEC: begin
        unique case (op)
          FN_PALLOC, FN_PFREE: state_next = S_OUT;
          FN_CALLOC: begin
            if (!ch_empty) state_next = S_CPOP;
            else if (!ph_empty) state_next = S_SPLIT;
            else state_next = S_OUT;
          end
          FN_CFREE: begin
            if (st_valid && !(st_mask[op_sub]) &&
                ((st_mask | bit_sel) == FULL_MASK) && (st_cnt + 1'b1 == NW'(CPP)))
              state_next = S_WALK2;
            else state_next = S_OUT;
          end
        endcase
      end
      S_SPLIT:  if (split_i == SW'(CPP - 1)) state_next = S_RD;
      S_CPOP:   state_next = S_OUT;
      S_WALK:   state_next = (cur[CW] || walk_over) ? S_PUSHPG : S_WALK2;
      S_WALK2:  state_next = S_WALK;
      S_PUSHPG: state_next = S_OUT;
      S_OUT:    if (!res_valid || out_acc) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    bit_sel = '0;
    bit_sel[op_sub] = 1'b1;
  end

  // memory accesses
  always_comb begin
    pl_we = 1'b0; pl_wa = op_page; pl_wd = page_head;
    pl_ra = page_head[PW-1:0];
    cl_we = 1'b0; cl_wa = {op_page, op_sub}; cl_wd = chunk_head;
    cl_ra = chunk_head[CW-1:0];
    st_we = 1'b0; st_wa = op_page; st_wd = {1'b1, st_mask | bit_sel, st_cnt + 1'b1};
    st_ra = op_page;
    unique case (state)
      S_CLEAR: begin
        st_we = 1'b1; st_wa = clr_addr; st_wd = '0;
      end
      S_RD: begin
        if (op == FN_CALLOC) st_ra = hc_page;
      end
      S_EXEC: begin
        if (op == FN_PFREE) pl_we = 1'b1;
        if (op == FN_CFREE && !(st_valid && st_mask[op_sub])) begin
          cl_we = 1'b1;
          st_we = st_valid;
        end
        if (op == FN_CFREE) cl_ra = {op_page, op_sub};
        if (op == FN_CALLOC) st_ra = hc_page;
      end
      S_SPLIT: begin
        cl_we = 1'b1; cl_wa = split_chunk;
        if (split_i == '0) begin
          st_we = 1'b1; st_wa = page_head[PW-1:0]; st_wd = {1'b1, FULL_MASK, NW'(CPP)};
        end
      end
      S_CPOP: begin
        if (st_valid && st_mask[hc_sub]) begin
          st_we = 1'b1; st_wa = hc_page;
          st_wd = {1'b1, st_mask & ~(CPP'(1) << hc_sub),
                   (st_cnt != '0) ? st_cnt - 1'b1 : st_cnt};
        end
      end
      S_WALK: begin
        cl_ra = cur[CW-1:0];
        if (!cur[CW] && !walk_over && cur[CW-1:SW] == op_page && !prev[CW]) begin
          cl_we = 1'b1; cl_wa = prev[CW-1:0]; cl_wd = cl_rd;
        end
      end
      S_WALK2:  cl_ra = cur[CW-1:0];
      S_PUSHPG: begin
        pl_we = 1'b1;
        st_we = 1'b1; st_wd = '0;
      end
      default: ;
    endcase
  end

  // note: in S_WALK cl_rd holds link of cur (read issued in previous cycle)
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      page_head   <= PW'(0) | (PW+1)'(PAGES);
      chunk_head  <= (CW+1)'(TOTAL);
      page_total  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!res_valid || out_acc)) res_valid <= 1'b1;
      else if (out_acc) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (in_acc) begin
            op       <= func_t'(func);
            op_page  <= (func == FN_PFREE) ? page_number : chunk_number[CW-1:SW];
            op_sub   <= chunk_number[SW-1:0];
            split_i  <= '0;
            r_status <= ST_OK;
            r_gpage  <= '0;
            r_gchunk <= '0;
          end
        end
        S_EXEC: begin
          unique case (op)
            FN_PALLOC: begin
              if (ph_empty) r_status <= ST_OOM;
              else begin
                r_gpage   <= page_head[PW-1:0];
                page_head <= pl_rd;
                if (page_total != '0) page_total <= page_total - 1'b1;
              end
            end
            FN_PFREE: begin
              page_head <= {1'b0, op_page};
              if (page_total != COUNT_MAX) page_total <= page_total + 1'b1;
            end
            FN_CALLOC: begin
              if (ch_empty && ph_empty) r_status <= ST_OOM;
            end
            FN_CFREE: begin
              if (st_valid && st_mask[op_sub]) r_status <= ST_DUP;
              else chunk_head <= {1'b0, op_page, op_sub};
              cur      <= {1'b0, op_page, op_sub};
              prev     <= (CW+1)'(TOTAL);
              walk_cnt <= '0;
              walk_over <= 1'b0;
            end
          endcase
        end
        S_SPLIT: begin
          chunk_head <= {1'b0, split_chunk};
          split_i    <= split_i + 1'b1;
          if (split_i == SW'(CPP - 1)) begin
            page_head <= pl_rd;
            if (page_total != '0) page_total <= page_total - 1'b1;
          end
        end
        S_CPOP: begin
          r_gchunk   <= chunk_head[CW-1:0];
          chunk_head <= cl_rd;
        end
        S_WALK: begin
          if (!cur[CW] && !walk_over) begin
            if (cur[CW-1:SW] == op_page) begin
              if (prev[CW]) chunk_head <= cl_rd;
            end else begin
              prev <= cur;
            end
            cur <= cl_rd;
            walk_cnt <= walk_cnt + 1'b1;
            if (walk_cnt == (CW+1)'(TOTAL)) walk_over <= 1'b1;
          end
        end
        S_PUSHPG: begin
          page_head <= {1'b0, op_page};
          if (page_total != COUNT_MAX) page_total <= page_total + 1'b1;
        end
        S_OUT: begin
          if (!res_valid || out_acc) begin
            status        <= r_status;
            granted_page  <= r_gpage;
            granted_chunk <= r_gchunk;
            free_pages    <= page_total;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = res_valid;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_chunk))
    else $error("result dropped");
  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OOM |-> granted_page == '0 && granted_chunk == '0)
    else $error("grant on out of memory");
endmodule

### tb/sv/page_and_subpage_chunk_allocator_tb.sv
// Testbench for page_and_subpage_chunk_allocator: directed and random page and
// chunk traffic, checked against a scoreboard that tracks both free lists.
// Depends on pscalloc_pkg and the allocator RTL.
`timescale 1ns / 1ps

import pscalloc_pkg::*;

typedef struct {
  status_t     st;
  logic [9:0]  gpage;
  logic [11:0] gchunk;
  logic [10:0] npages;
} alloc_result_t;

class alloc_scoreboard;
  logic [10:0]     page_next [PAGES];
  logic [10:0]     page_top;
  logic [12:0]     chunk_next [TOTAL];
  logic [12:0]     chunk_top;
  bit              is_split [PAGES];
  logic [CPP-1:0]  free_bits [PAGES];
  logic [2:0]      free_cnt [PAGES];
  logic [10:0]     page_cnt;
  alloc_result_t   awaited [$];
  int              errors;

  function new();
    page_top = 11'(PAGES);
    chunk_top = 13'(TOTAL);
    page_cnt = 0;
    errors = 0;
    foreach (is_split[i]) is_split[i] = 0;
  endfunction

  function void push_pg(logic [9:0] p);
    page_next[p] = page_top;
    page_top = {1'b0, p};
    if (page_cnt < COUNT_MAX) page_cnt++;
  endfunction

  function bit pop_pg(output logic [9:0] p);
    if (page_top >= PAGES) return 0;
    p = page_top[9:0];
    page_top = page_next[p];
    if (page_cnt > 0) page_cnt--;
    return 1;
  endfunction

  function void push_ck(logic [11:0] c);
    chunk_next[c] = chunk_top;
    chunk_top = {1'b0, c};
  endfunction

  function void unlink_page(logic [9:0] pg);
    logic [12:0] cur, prev, nxt;
    int steps;
    cur = chunk_top;
    prev = 13'(TOTAL);
    steps = 0;
    while (cur < TOTAL && steps <= TOTAL) begin
      nxt = chunk_next[cur[11:0]];
      if (cur[11:2] == pg) begin
        if (prev >= TOTAL) chunk_top = nxt;
        else chunk_next[prev[11:0]] = nxt;
      end else begin
        prev = cur;
      end
      cur = nxt;
      steps++;
    end
  endfunction

  // Predict the result of one accepted beat and queue it.
  function alloc_result_t note(func_t f, logic [9:0] pnum, logic [11:0] cnum);
    alloc_result_t r;
    logic [9:0] p, pg;
    logic [11:0] c;
    logic [CPP-1:0] bitm;
    r.st = ST_OK;
    r.gpage = 0;
    r.gchunk = 0;
    case (f)
      FN_PALLOC: begin
        if (pop_pg(p)) r.gpage = p;
        else r.st = ST_OOM;
      end
      FN_PFREE: push_pg(pnum);
      FN_CALLOC: begin
        if (chunk_top >= TOTAL && pop_pg(p)) begin
          is_split[p] = 1;
          free_bits[p] = FULL_MASK;
          free_cnt[p] = 3'(CPP);
          for (int i = 0; i < CPP; i++) push_ck({p, 2'(i)});
        end
        if (chunk_top >= TOTAL) begin
          r.st = ST_OOM;
        end else begin
          c = chunk_top[11:0];
          pg = c[11:2];
          bitm = 4'b1 << c[1:0];
          chunk_top = chunk_next[c];
          if (is_split[pg] && (free_bits[pg] & bitm) != 0) begin
            free_bits[pg] &= ~bitm;
            if (free_cnt[pg] > 0) free_cnt[pg]--;
          end
          r.gchunk = c;
        end
      end
      default: begin
        pg = cnum[11:2];
        bitm = 4'b1 << cnum[1:0];
        if (!is_split[pg]) begin
          push_ck(cnum);
        end else if ((free_bits[pg] & bitm) != 0) begin
          r.st = ST_DUP;
        end else begin
          free_bits[pg] |= bitm;
          free_cnt[pg]++;
          push_ck(cnum);
          if (free_cnt[pg] == CPP && free_bits[pg] == FULL_MASK) begin
            unlink_page(pg);
            is_split[pg] = 0;
            push_pg(pg);
          end
        end
      end
    endcase
    r.npages = page_cnt;
    awaited.push_back(r);
    return r;
  endfunction

  function void check(logic [1:0] st, logic [9:0] gp, logic [11:0] gc, logic [10:0] fp);
    alloc_result_t e;
    if (awaited.size() == 0) begin
      $error("result beat with nothing awaited");
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (st !== e.st) begin
      $error("status: expected %0d, got %0d", e.st, st);
      errors++;
    end
    if (gp !== e.gpage) begin
      $error("granted_page: expected %0d, got %0d", e.gpage, gp);
      errors++;
    end
    if (gc !== e.gchunk) begin
      $error("granted_chunk: expected %0d, got %0d", e.gchunk, gc);
      errors++;
    end
    if (fp !== e.npages) begin
      $error("free_pages: expected %0d, got %0d", e.npages, fp);
      errors++;
    end
  endfunction
endclass

module page_and_subpage_chunk_allocator_tb;
  localparam int LIMIT = 40000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] func = FN_PALLOC;
  logic [9:0] page_number = 0;
  logic [11:0] chunk_number = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [9:0] granted_page;
  logic [11:0] granted_chunk;
  logic [10:0] free_pages;

  alloc_scoreboard sb = new();
  logic [9:0] held_pages [$];
  logic [11:0] held_chunks [$];
  bit send_busy = 0;
  bit recv_busy = 0;
  int cycles = 0;

  page_and_subpage_chunk_allocator uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(func_t f, logic [9:0] p, logic [11:0] c);
    int gap;
    alloc_result_t r;
    gap = send_busy ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    page_number <= p;
    chunk_number <= c;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    r = sb.note(f, p, c);
    if (f == FN_PALLOC && r.st == ST_OK) held_pages.push_back(r.gpage);
    if (f == FN_CALLOC && r.st == ST_OK) held_chunks.push_back(r.gchunk);
  endtask

  task automatic release_chunk();
    int k;
    logic [11:0] c;
    k = $urandom_range(0, held_chunks.size() - 1);
    c = held_chunks[k];
    held_chunks.delete(k);
    send(FN_CFREE, 10'($urandom), c);
  endtask

  task automatic release_page();
    int k;
    logic [9:0] p;
    k = $urandom_range(0, held_pages.size() - 1);
    p = held_pages[k];
    held_pages.delete(k);
    send(FN_PFREE, p, 12'($urandom));
  endtask

  initial begin
    int stall;
    repeat (7) @(posedge clk);
    rst <= 0;
    forever begin
      stall = recv_busy ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      sb.check(status, granted_page, granted_chunk, free_pages);
    end
  end

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    @(posedge clk);
    send(FN_PALLOC, 10'h3ff, 12'hfff);
    send(FN_CALLOC, 10'h155, 12'h555);
    send(FN_CFREE, 0, 12'hfff);
    send(FN_CALLOC, 0, 0);
    send(FN_PFREE, 10'h3ff, 0);
    send(FN_PFREE, 10'h000, 0);
    send(FN_PFREE, 10'h3ff, 0);
    send(FN_PALLOC, 0, 0);
    send(FN_PFREE, 10'h3ff, 0);
    send(FN_PFREE, 10'h2aa, 0);
    send(FN_PFREE, 10'h155, 0);
    send(FN_CALLOC, 0, 0);
    send(FN_CFREE, 0, 12'h557);
    send(FN_CALLOC, 0, 0);
    send(FN_CALLOC, 0, 0);
    send(FN_CFREE, 0, 12'h556);
    send(FN_CFREE, 0, 12'h556);
    send(FN_CFREE, 0, 12'haaa);
    send(FN_PALLOC, 0, 0);
    send(FN_CFREE, 0, 12'h000);
    held_pages.delete();
    held_chunks.delete();
    for (int i = 0; i < 24; i++) send(FN_PFREE, 10'($urandom), 12'($urandom));

    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) begin
        send_busy = ($urandom_range(0, 3) == 0);
        recv_busy = ($urandom_range(0, 3) == 0);
      end
      if (n == 600) begin
        in_valid <= 0;
        while (sb.awaited.size() > 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) send(FN_CALLOC, 10'($urandom), 12'($urandom));
      else if (pick < 60 && held_chunks.size() > 0) release_chunk();
      else if (pick < 65) send(FN_CFREE, 10'($urandom), 12'($urandom));
      else if (pick < 80) send(FN_PALLOC, 10'($urandom), 12'($urandom));
      else if (pick < 95 && held_pages.size() > 0) release_page();
      else send(FN_PFREE, 10'($urandom), 12'($urandom));
    end
    in_valid <= 0;

    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
